// ===== rtl/core/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
`default_nettype none

package spq_pkg;

	// Operation codes carried on the operation port
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} spq_status_t;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;
		logic rem;
	} spq_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted chain: holds a key and trades it with its neighbors.
`default_nettype none

module spq_cell #(
	parameter int KEY_WIDTH = 32
) (
	input  wire                         clk,
	input  wire spq_pkg::spq_cmd_t      cmd,
	input  wire                         occupied,
	input  wire signed [KEY_WIDTH-1:0]  key,
	input  wire signed [KEY_WIDTH-1:0]  prev_entry,
	input  wire                         prev_gt,
	input  wire signed [KEY_WIDTH-1:0]  next_entry,
	output logic signed [KEY_WIDTH-1:0] entry,
	output logic                        gt
);

	logic signed [KEY_WIDTH-1:0] entry_q;

	// Flag slots that the new key goes in front of (free slots count too)
	assign gt    = !occupied || (key < entry_q);
	assign entry = entry_q;

	// Insert: the first flagged slot takes the key, later ones shift right.
	// Remove: every slot takes its right neighbor.
	always_ff @(posedge clk) begin
		if (cmd.ins && gt) begin
			entry_q <= prev_gt ? prev_entry : key;
		end else if (cmd.rem) begin
			entry_q <= next_entry;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell chain, count and result registers.
`default_nettype none

// Bounded min-priority queue held as a chain of CAPACITY cells in ascending
// order. Each word is an insert of value or a removal of the smallest entry.
// Every cell compares the broadcast key against its own entry in parallel,
// so busy stays low and a new word can be started every cycle. The result
// strobes on result_valid in the cycle after the word is accepted and holds
// for that cycle only; the receiver must take it then. Equal keys leave in
// arrival order. An insert into a full queue or a removal from an empty
// queue leaves the queue unchanged and is flagged in status. Values are
// wrapped to KEY_WIDTH bits as signed keys.
module sorted_priority_queue #(
	parameter int CAPACITY  = 16,
	parameter int KEY_WIDTH = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire               operation,
	input  wire signed [31:0] value,
	output logic              result_valid,
	output logic signed [31:0] head_value,
	output logic              queue_empty,
	output logic [4:0]        entry_count,
	output logic [1:0]        status
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic                        accept;
	logic                        is_full;
	logic                        is_empty;
	spq_pkg::spq_cmd_t           cmd;
	logic signed [KEY_WIDTH-1:0] key;
	logic signed [KEY_WIDTH-1:0] entries [CAPACITY];
	logic [CAPACITY-1:0]         gts;
	logic [CW-1:0]               count_q;
	logic                        result_valid_q;
	spq_pkg::spq_status_t        status_q;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign is_full  = (count_q == CW'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign key      = KEY_WIDTH'(value);

	// Decode the word into a chain command; drop illegal ones
	assign cmd.ins = accept && (operation == spq_pkg::OP_INSERT) && !is_full;
	assign cmd.rem = accept && (operation == spq_pkg::OP_REMOVE) && !is_empty;

	// Build the chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [KEY_WIDTH-1:0] prev_entry;
		logic                        prev_gt;
		logic signed [KEY_WIDTH-1:0] next_entry;

		if (i == 0) begin : g_first
			assign prev_entry = key;
			assign prev_gt    = 1'b0;
		end else begin : g_mid
			assign prev_entry = entries[i-1];
			assign prev_gt    = gts[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_entry = '0;
		end else begin : g_inner
			assign next_entry = entries[i+1];
		end

		spq_cell #(
			.KEY_WIDTH(KEY_WIDTH)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occupied  (count_q > CW'(i)),
			.key       (key),
			.prev_entry(prev_entry),
			.prev_gt   (prev_gt),
			.next_entry(next_entry),
			.entry     (entries[i]),
			.gt        (gts[i])
		);
	end

	// Track the entry count and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			result_valid_q <= 1'b0;
			status_q       <= spq_pkg::ST_DONE;
		end else begin
			result_valid_q <= accept;
			if (cmd.ins) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.rem) begin
				count_q <= count_q - CW'(1);
			end
			if (accept) begin
				if (operation == spq_pkg::OP_INSERT) begin
					status_q <= is_full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
				end else begin
					status_q <= is_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_DONE;
				end
			end
		end
	end

	// Present the head of the chain
	assign result_valid = result_valid_q;
	assign queue_empty  = is_empty;
	assign entry_count  = 5'(count_q);
	assign status       = status_q;
	assign head_value   = is_empty ? 32'sd0 : 32'(entries[0]);

	// A legal insert grows the count by one
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + CW'(1))
		else $error("count did not grow on insert");

	// A remove on an empty queue reports the empty status
	a_rem_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (operation == spq_pkg::OP_REMOVE) && is_empty
		|=> result_valid && (status_q == spq_pkg::ST_EMPTY) && is_empty)
		else $error("empty remove misreported");

	// A result appears only in the cycle after an accepted word
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(accept))
		else $error("result without a word");

	// The two front entries stay in order
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(2)) |-> (entries[0] <= entries[1]))
		else $error("front of chain out of order");

endmodule

`default_nettype wire
